FILE: sv/wrs_pkg.sv
// Package for the word reversal stream: store sizes, delimiter codes and the
// command type that passes from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package wrs_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PERIOD = 8'd46;

  typedef struct packed {
    logic [7:0] ch;
    logic       delim;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DELIM
  } back_state_t;

endpackage

FILE: sv/wrs_front.sv
// Front end: accepts input bytes, marks delimiters and holds them in a short
// command queue for the back end.
// Depends on wrs_pkg.
`timescale 1ns / 1ps

module wrs_front import wrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              push;
  logic              pop;
  cmd_t              new_cmd;

  assign in_ready  = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    new_cmd.ch    = in_char;
    new_cmd.delim = (in_char == CHAR_SPACE) || (in_char == CHAR_PERIOD);
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    count_nxt     = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

FILE: sv/wrs_back.sv
// Back end: letter store with its level and sticky overflow flag, the flush
// sequencer and the output register.
// Depends on wrs_pkg.
`timescale 1ns / 1ps

module wrs_back import wrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       out_overflow
);

  logic [7:0]        mem_r [STACK_DEPTH];
  logic [7:0]        rd_data_r;
  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [LVL_W-1:0]  level_r;
  logic [LVL_W-1:0]  level_nxt;
  logic [LVL_W-1:0]  level_dec;
  logic              drop_r;
  logic              drop_nxt;
  logic [7:0]        delim_r;
  logic [7:0]        delim_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [7:0]        out_char_r;
  logic [7:0]        out_char_nxt;
  logic              out_last_r;
  logic              out_last_nxt;
  logic              out_ovf_r;
  logic              out_ovf_nxt;
  logic              slot_free;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign level_dec    = level_r - LVL_W'(1);
  assign wr_addr      = level_r[ADDR_W-1:0];
  assign rd_addr      = level_dec[ADDR_W-1:0];
  assign slot_free    = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    drop_nxt      = drop_r;
    delim_nxt     = delim_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    cmd_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (!cmd.delim) begin
            if (level_r < LVL_W'(STACK_DEPTH)) begin
              wr_en     = 1'b1;
              level_nxt = level_r + LVL_W'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end else begin
            delim_nxt = cmd.ch;
            if (level_r != '0) begin
              rd_en     = 1'b1;
              level_nxt = level_dec;
              state_nxt = S_LOAD;
            end else begin
              state_nxt = S_DELIM;
            end
          end
        end
      end
      S_LOAD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rd_data_r;
          out_last_nxt  = 1'b0;
          out_ovf_nxt   = drop_r;
          if (level_r != '0) begin
            rd_en     = 1'b1;
            level_nxt = level_dec;
          end else begin
            state_nxt = S_DELIM;
          end
        end
      end
      S_DELIM: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = delim_r;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = drop_r;
          drop_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delim_r    <= delim_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= cmd.ch;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

FILE: sv/word_reverse_stack_stream.sv
// Top level of the word reversal stream: front end, command queue and back end.
// Depends on wrs_pkg, wrs_front and wrs_back.
//
//   Channel  Ports                                          Direction
//   in       in_valid, in_ready, in_char                    into the block
//   out      out_valid, out_ready, out_char, out_last,      out of the block
//            out_overflow
//
// A letter is written to the letter store as the back end accepts it. A delimiter
// starts the flush, which reads the stored letters back one at a time from the
// single-port letter store, newest first, and then sends the delimiter itself.
// The two-entry command queue takes bytes during a flush until it is full.
// Reset is synchronous and active low; it empties the queue, the store level,
// the overflow flag and the output register. The letter store needs no clearing.
// A stalled output holds its transaction and pauses the flush in place.
`timescale 1ns / 1ps

module word_reverse_stack_stream import wrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       out_overflow
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  wrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  wrs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

endmodule

FILE: sv/wrs_checker.sv
// Port-level checker for the word reversal stream, bound to the top level.
// Depends on wrs_pkg and word_reverse_stack_stream.
`timescale 1ns / 1ps

module wrs_checker import wrs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_char,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic       out_overflow
);

  logic             mid_r;
  logic             ovf_r;
  logic [LVL_W-1:0] cnt_r;
  logic             out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
    end else if (out_fire) begin
      mid_r <= !out_last;
      ovf_r <= out_overflow;
      cnt_r <= out_last ? '0 : cnt_r + LVL_W'(1);
    end
  end

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(out_last) && $stable(out_overflow))
    else $error("stalled result changed");

  a_letter_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == ((out_char == CHAR_SPACE) || (out_char == CHAR_PERIOD))))
    else $error("last mark disagrees with the byte kind");

  a_flush_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mid_r |-> out_overflow == ovf_r)
    else $error("overflow changed within one flush");

  a_flush_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> cnt_r < LVL_W'(STACK_DEPTH))
    else $error("flush longer than the letter store");

endmodule

bind word_reverse_stack_stream wrs_checker u_wrs_checker (.*);

FILE: test/word_reverse_stack_stream_check.sv
// Checker for the word reversal stream: watches both channels, predicts every
// output transaction from the accepted input bytes and compares field by field.
// Depends on wrs_pkg for the store depth and the delimiter codes.
`timescale 1ns / 1ps

module word_reverse_stack_stream_check import wrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       out_last,
  input  logic       out_overflow,
  output int         error_count,
  output int         pending_beats
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } word_beat_t;

  word_beat_t  reversed_beats[$];
  logic [7:0]  letters [STACK_DEPTH];
  int unsigned letter_level = 0;
  logic        dropped = 1'b0;
  int          mismatches = 0;

  assign error_count = mismatches;

  task automatic reverse_byte(input logic [7:0] c);
    word_beat_t beat;
    logic       ovf_now;
    if (c != CHAR_SPACE && c != CHAR_PERIOD) begin
      if (letter_level < STACK_DEPTH) begin
        letters[letter_level[ADDR_W-1:0]] = c;
        letter_level++;
      end else begin
        dropped = 1'b1;
      end
    end else begin
      ovf_now = dropped;
      while (letter_level > 0) begin
        letter_level--;
        beat.ch = letters[letter_level[ADDR_W-1:0]];
        beat.last = 1'b0;
        beat.ovf = ovf_now;
        reversed_beats.push_back(beat);
      end
      beat.ch = c;
      beat.last = 1'b1;
      beat.ovf = ovf_now;
      reversed_beats.push_back(beat);
      dropped = 1'b0;
    end
  endtask

  task automatic compare_beat();
    word_beat_t want;
    if (reversed_beats.size() == 0) begin
      $error("out transaction with nothing expected: out_char %0d", out_char);
      mismatches++;
    end else begin
      want = reversed_beats.pop_front();
      if (out_char !== want.ch) begin
        $error("out_char: expected %0d, actual %0d", want.ch, out_char);
        mismatches++;
      end
      if (out_last !== want.last) begin
        $error("out_last: expected %0b, actual %0b", want.last, out_last);
        mismatches++;
      end
      if (out_overflow !== want.ovf) begin
        $error("out_overflow: expected %0b, actual %0b", want.ovf, out_overflow);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      letter_level = 0;
      dropped = 1'b0;
      reversed_beats.delete();
    end else begin
      if (in_valid && in_ready) reverse_byte(in_char);
      if (out_valid && out_ready) compare_beat();
    end
    pending_beats <= reversed_beats.size();
  end

endmodule

FILE: test/word_reverse_stack_stream_test.sv
// Top of the word reversal stream testbench: clock, reset, byte stimulus with
// random gaps, receiver stalls, a watchdog and the verdict.
// Depends on wrs_pkg, word_reverse_stack_stream and word_reverse_stack_stream_check.
`timescale 1ns / 1ps

module word_reverse_stack_stream_test;
  import wrs_pkg::*;

  localparam int ITEM_TARGET = 220;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = STACK_DEPTH + 8;
  localparam int HOLD_AT = 250;
  localparam int HOLD_CYCLES = 150;
  localparam int RX_QUIET_FROM = 100;
  localparam int RX_QUIET_TO = 220;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;
  logic       out_overflow;
  int         check_errors;
  int         check_pending;

  bit          send_idle = 1'b1;
  int unsigned bytes_sent = 0;

  logic [7:0] opening_text [0:15] = '{
    CHAR_SPACE, CHAR_PERIOD, 8'h00, CHAR_SPACE, 8'hFF, CHAR_PERIOD, 8'h0A, 8'h80,
    8'h61, 8'h5A, CHAR_SPACE, 8'h7F, 8'h01, 8'h55, 8'hAA, CHAR_PERIOD
  };

  always #5 clk = ~clk;

  word_reverse_stack_stream u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

  word_reverse_stack_stream_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char       (in_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last      (out_last),
    .out_overflow  (out_overflow),
    .error_count   (check_errors),
    .pending_beats (check_pending)
  );

  task automatic send_byte(input logic [7:0] b);
    if (send_idle && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Most letters are proper letters; about one in ten is any byte at all, so
  // stray delimiters break words up now and then.
  task automatic send_word(input int unsigned len);
    logic [7:0] c;
    repeat (len) begin
      if ($urandom_range(9) == 0) begin
        c = 8'($urandom_range(255));
      end else begin
        do c = 8'($urandom_range(255)); while (c == CHAR_SPACE || c == CHAR_PERIOD);
      end
      send_byte(c);
    end
    send_byte($urandom_range(1) ? CHAR_SPACE : CHAR_PERIOD);
  endtask

  initial begin : stimulus
    int unsigned word_count;
    int unsigned pick;
    word_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening_text[i]) send_byte(opening_text[i]);
    while (bytes_sent < ITEM_TARGET) begin
      send_idle = !(word_count >= 4 && word_count < 9);
      pick = $urandom_range(99);
      if (word_count == 2) send_word(STACK_DEPTH + 2);
      else if (pick < 60) send_word($urandom_range(0, 6));
      else if (pick < 88) send_word($urandom_range(7, STACK_DEPTH - 1));
      else send_word($urandom_range(STACK_DEPTH, STACK_DEPTH + 4));
      word_count++;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (check_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // The long hold-off lets the input side fill the block until it stalls.
  initial begin : receiver
    int unsigned rx_cycle;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_cycle >= RX_QUIET_FROM && rx_cycle < RX_QUIET_TO) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 12);
    end
  end

  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
